// ----- sv/igmp_rmt_pkg.sv -----
// ----------------------------------------------------------------------------
// IGMP router membership table package
// Shared constants, codes and record types of the membership table.
// ----------------------------------------------------------------------------
package igmp_rmt_pkg;

    localparam int GROUP_ENTRIES = 16;
    localparam int RESULT_LIMIT  = 17;
    localparam int IDX_W = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
    localparam int CNT_W = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [1:0] {
        KIND_REPORT,
        KIND_LEAVE,
        KIND_QUERY,
        KIND_TICK
    } kind_t;

    typedef enum logic [2:0] {
        OUT_GENQ,
        OUT_GRPQ,
        OUT_REG,
        OUT_UNREG,
        OUT_FULL
    } out_kind_t;

    typedef enum logic [2:0] {
        CFG_QUERY_INTERVAL,
        CFG_QUERY_RESP_INTERVAL,
        CFG_GROUP_MEMB_INTERVAL,
        CFG_OTHER_QUERIER_INTERVAL,
        CFG_LAST_MEMBER_INTERVAL,
        CFG_LAST_MEMBER_COUNT,
        CFG_OWN_ADDRESS
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [15:0] query_interval;
        logic [7:0]  query_response_interval;
        logic [15:0] group_membership_interval;
        logic [15:0] other_querier_interval;
        logic [11:0] last_member_interval;
        logic [3:0]  last_member_count;
        logic [31:0] own_address;
    } cfg_t;

    typedef struct packed {
        logic [31:0] group;
        logic        checking;
        logic [15:0] member_timer;
        logic [15:0] rexmt_timer;
    } entry_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        out_kind_t   kind;
        logic [31:0] group;
        logic [7:0]  max_resp;
    } result_t;

    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

// ----- sv/igmp_rmt_if.sv -----
// ----------------------------------------------------------------------------
// IGMP router membership table channels
// Input, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface igmp_rmt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] group_addr;
    logic [31:0] sender_addr;

    modport source (output valid, kind, group_addr, sender_addr, input ready);
    modport sink (input valid, kind, group_addr, sender_addr, output ready);
endinterface

interface igmp_rmt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [31:0] out_group;
    logic [7:0]  max_resp;
    logic        last;

    modport source (output valid, out_kind, out_group, max_resp, last, input ready);
    modport sink (input valid, out_kind, out_group, max_resp, last, output ready);
endinterface

interface igmp_rmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/igmp_router_membership_table.sv -----
// ----------------------------------------------------------------------------
// IGMP router membership table
// Router side IGMPv2 group membership for one interface, 100 ms ticks.
// ----------------------------------------------------------------------------
// Channels: in_ch carries reports, leaves, queries and ticks; out_ch carries
// general and group queries, register/unregister notices and table-full
// drops, with last set on the final result of each input transaction; cfg
// writes the interval and address registers and is always ready.
// A query transaction is taken without leaving idle and gives no result. A
// report, leave or tick walks every table entry through the single entry
// memory, a read step and an evaluate/write-back step per entry, then passes
// the finish and flush states before in_ch is ready again; a stalled out_ch
// can hold the tick walk and the flush.
// Results leave through an output register backed by one pending stage; a
// stalled receiver holds the table walk at the entry that wants to emit.
// Reset empties the table through its valid flops, makes the block querier
// and arms a general query on the first tick; the registers take their
// default intervals. No clearing pass is needed.
// ----------------------------------------------------------------------------
module igmp_router_membership_table
    import igmp_rmt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    igmp_rmt_in_if.sink    in_ch,
    igmp_rmt_out_if.source out_ch,
    igmp_rmt_cfg_if.sink   cfg
);

    cfg_t     regs;
    mem_req_t mem_req;
    entry_t   rd_data;

    igmp_rmt_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    igmp_rmt_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    igmp_rmt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .regs    (regs),
        .rd_data (rd_data),
        .mem_req (mem_req)
    );

    a_query_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.kind == KIND_QUERY) |=> in_ch.ready)
        else $error("query transaction blocked the input");

    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.kind != KIND_QUERY) |=> !in_ch.ready)
        else $error("table walk did not start");

    a_genq_group: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.out_kind == OUT_GENQ) |-> out_ch.out_group == 32'd0)
        else $error("general query with nonzero group");

    a_notice_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.out_kind == OUT_REG || out_ch.out_kind == OUT_UNREG
                          || out_ch.out_kind == OUT_FULL)) |-> out_ch.max_resp == 8'd0)
        else $error("notice with nonzero max response");

endmodule

// ----- sv/igmp_rmt_cfg.sv -----
// ----------------------------------------------------------------------------
// IGMP router membership table configuration registers
// Holds the timer intervals and own address written over the config channel.
// ----------------------------------------------------------------------------
module igmp_rmt_cfg
    import igmp_rmt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    igmp_rmt_cfg_if.sink  cfg,
    output cfg_t          regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_QUERY_INTERVAL:         regs_next.query_interval = cfg.data[15:0];
                CFG_QUERY_RESP_INTERVAL:    regs_next.query_response_interval = cfg.data[7:0];
                CFG_GROUP_MEMB_INTERVAL:    regs_next.group_membership_interval = cfg.data[15:0];
                CFG_OTHER_QUERIER_INTERVAL: regs_next.other_querier_interval = cfg.data[15:0];
                CFG_LAST_MEMBER_INTERVAL:   regs_next.last_member_interval = cfg.data[11:0];
                CFG_LAST_MEMBER_COUNT:      regs_next.last_member_count = cfg.data[3:0];
                CFG_OWN_ADDRESS:            regs_next.own_address = cfg.data;
                default:                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.query_interval            <= 16'd1250;
            regs_reg.query_response_interval   <= 8'd100;
            regs_reg.group_membership_interval <= 16'd2600;
            regs_reg.other_querier_interval    <= 16'd2550;
            regs_reg.last_member_interval      <= 12'd10;
            regs_reg.last_member_count         <= 4'd2;
            regs_reg.own_address               <= 32'd0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- sv/igmp_rmt_mem.sv -----
// ----------------------------------------------------------------------------
// IGMP router membership table entry memory
// One write port and one registered read port holding the group entries.
// ----------------------------------------------------------------------------
module igmp_rmt_mem
    import igmp_rmt_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [GROUP_ENTRIES];
    entry_t rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

endmodule

// ----- sv/igmp_rmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// IGMP router membership table controller
// Sequences lookups and timer sweeps over the entry memory and queues results.
// ----------------------------------------------------------------------------
module igmp_rmt_ctrl
    import igmp_rmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    igmp_rmt_in_if.sink           in_ch,
    igmp_rmt_out_if.source        out_ch,
    input  cfg_t                  regs,
    input  entry_t                rd_data,
    output mem_req_t              mem_req
);

    state_t                   state_reg, state_next;
    kind_t                    kind_reg, kind_next;
    logic [31:0]              group_reg, group_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic                     querier_reg, querier_next;
    logic [15:0]              qtimer_reg, qtimer_next;
    logic [GROUP_ENTRIES-1:0] valid_reg, valid_next;
    logic                     match_reg, match_next;
    logic [IDX_W-1:0]         match_idx_reg, match_idx_next;
    entry_t                   match_entry_reg, match_entry_next;
    logic                     pend_valid_reg, pend_valid_next;
    result_t                  pend_reg, pend_next;
    logic                     out_valid_reg, out_valid_next;
    result_t                  out_reg, out_next;
    logic                     out_last_reg, out_last_next;

    logic [11:0]      lmi1;
    logic [7:0]       grp_mr;
    logic [15:0]      leave_timer;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             out_free;
    logic             mexp;
    logic             rexp;
    logic             emits;
    logic             at_limit;
    entry_t           upd;

    assign lmi1        = (regs.last_member_interval == 12'd0) ? 12'd1
                                                              : regs.last_member_interval;
    assign grp_mr      = (lmi1 > 12'd255) ? 8'd255 : lmi1[7:0];
    assign leave_timer = at_least_one(16'(regs.last_member_interval * regs.last_member_count));
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_kind  = out_reg.kind;
    assign out_ch.out_group = out_reg.group;
    assign out_ch.max_resp  = out_reg.max_resp;
    assign out_ch.last      = out_last_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < GROUP_ENTRIES; i++)
        begin
            if (!valid_reg[i] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        mexp     = (rd_data.member_timer <= 16'd1);
        rexp     = !mexp && (rd_data.rexmt_timer == 16'd1);
        emits    = valid_reg[idx_reg] && (mexp || (rexp && querier_reg));
        at_limit = (n_reg >= CNT_W'(RESULT_LIMIT));
        upd      = rd_data;
        upd.member_timer = rd_data.member_timer - 16'd1;
        if (rexp)
        begin
            upd.rexmt_timer = {4'd0, lmi1};
            upd.checking    = 1'b1;
        end
        else if (rd_data.rexmt_timer != 16'd0)
        begin
            upd.rexmt_timer = rd_data.rexmt_timer - 16'd1;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        group_next       = group_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        querier_next     = querier_reg;
        qtimer_next      = qtimer_reg;
        valid_next       = valid_reg;
        match_next       = match_reg;
        match_idx_next   = match_idx_reg;
        match_entry_next = match_entry_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        out_last_next    = out_last_reg;
        mem_req          = '0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    kind_next  = kind_t'(in_ch.kind);
                    group_next = in_ch.group_addr;
                    idx_next   = '0;
                    n_next     = '0;
                    match_next = 1'b0;
                    case (kind_t'(in_ch.kind))
                        KIND_QUERY:
                        begin
                            if (in_ch.sender_addr < regs.own_address)
                            begin
                                qtimer_next  = at_least_one(regs.other_querier_interval);
                                querier_next = 1'b0;
                            end
                        end
                        KIND_TICK:
                        begin
                            if (qtimer_reg <= 16'd1)
                            begin
                                querier_next       = 1'b1;
                                pend_valid_next    = 1'b1;
                                pend_next.kind     = OUT_GENQ;
                                pend_next.group    = 32'd0;
                                pend_next.max_resp = regs.query_response_interval;
                                n_next             = CNT_W'(1);
                                qtimer_next        = at_least_one(regs.query_interval);
                            end
                            else
                            begin
                                qtimer_next = qtimer_reg - 16'd1;
                            end
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_READ;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
                state_next      = ST_EVAL;
            end

            ST_EVAL:
            begin
                logic advance;
                advance = 1'b1;
                if (kind_reg == KIND_TICK)
                begin
                    if (valid_reg[idx_reg] && !(emits && at_limit))
                    begin
                        if (emits)
                        begin
                            if (pend_valid_reg && !out_free)
                            begin
                                advance = 1'b0;
                            end
                            else
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next       = pend_reg;
                                    out_last_next  = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_next.kind  = mexp ? OUT_UNREG : OUT_GRPQ;
                                pend_next.group = rd_data.group;
                                pend_next.max_resp = mexp ? 8'd0 : grp_mr;
                                n_next          = n_reg + CNT_W'(1);
                            end
                        end
                        if (advance)
                        begin
                            if (mexp)
                            begin
                                valid_next[idx_reg] = 1'b0;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = idx_reg;
                                mem_req.wr_data = upd;
                            end
                        end
                    end
                end
                else if (valid_reg[idx_reg] && rd_data.group == group_reg)
                begin
                    match_next       = 1'b1;
                    match_idx_next   = idx_reg;
                    match_entry_next = rd_data;
                end

                if (advance)
                begin
                    if (idx_reg == IDX_W'(GROUP_ENTRIES - 1))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            ST_FINISH:
            begin
                state_next = ST_FLUSH;
                case (kind_reg)
                    KIND_REPORT:
                    begin
                        mem_req.wr_data.group        = group_reg;
                        mem_req.wr_data.checking     = 1'b0;
                        mem_req.wr_data.member_timer =
                            at_least_one(regs.group_membership_interval);
                        mem_req.wr_data.rexmt_timer  = 16'd0;
                        pend_next.group    = group_reg;
                        pend_next.max_resp = 8'd0;
                        if (match_reg)
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = match_idx_reg;
                        end
                        else if (free_found)
                        begin
                            mem_req.wr_en        = 1'b1;
                            mem_req.wr_addr      = free_idx;
                            valid_next[free_idx] = 1'b1;
                            pend_valid_next      = 1'b1;
                            pend_next.kind       = OUT_REG;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            pend_next.kind  = OUT_FULL;
                        end
                    end
                    KIND_LEAVE:
                    begin
                        if (match_reg && !match_entry_reg.checking)
                        begin
                            mem_req.wr_en                = 1'b1;
                            mem_req.wr_addr              = match_idx_reg;
                            mem_req.wr_data.group        = group_reg;
                            mem_req.wr_data.checking     = 1'b1;
                            mem_req.wr_data.member_timer =
                                querier_reg ? leave_timer : match_entry_reg.member_timer;
                            mem_req.wr_data.rexmt_timer  = {4'd0, lmi1};
                        end
                    end
                    default:
                    begin
                        state_next = ST_FLUSH;
                    end
                endcase
            end

            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kind_reg       <= KIND_REPORT;
            idx_reg        <= '0;
            n_reg          <= '0;
            querier_reg    <= 1'b1;
            qtimer_reg     <= 16'd1;
            valid_reg      <= '0;
            match_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            querier_reg    <= querier_next;
            qtimer_reg     <= qtimer_next;
            valid_reg      <= valid_next;
            match_reg      <= match_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg       <= group_next;
        match_idx_reg   <= match_idx_next;
        match_entry_reg <= match_entry_next;
        pend_reg        <= pend_next;
        out_reg         <= out_next;
        out_last_reg    <= out_last_next;
    end

endmodule

// ----- tb/tb_igmp_router_membership_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IGMP router membership table testbench
// Drives reports, leaves, queries and ticks with random idling on both
// channels, predicts querier and group table behavior cycle-free, and checks
// every result transaction field by field against the predicted queue.
// ----------------------------------------------------------------------------
module tb_igmp_router_membership_table;
    import igmp_rmt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int WALK_CYCLES = 2 * GROUP_ENTRIES + 10;

    typedef struct {
        out_kind_t   kind;
        logic [31:0] group;
        logic [7:0]  max_resp;
        logic        last;
    } notice_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    igmp_rmt_in_if  in_ch ();
    igmp_rmt_out_if out_ch ();
    igmp_rmt_cfg_if cfg ();

    igmp_router_membership_table i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow registers and table
    int unsigned r_qi, r_qri, r_gmi, r_oqi, r_lmi, r_lmc, r_own;
    bit          m_querier;
    int unsigned m_qtimer;
    bit          m_valid [GROUP_ENTRIES];
    logic [31:0] m_group [GROUP_ENTRIES];
    bit          m_checking [GROUP_ENTRIES];
    int unsigned m_member [GROUP_ENTRIES];
    int unsigned m_rexmt [GROUP_ENTRIES];

    notice_t     pending_notices [$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          idle_en = 1'b1;
    int          hold_cycles = 0;
    logic [31:0] group_pool [16];

    function automatic int unsigned at_least_one_tick(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic void push_notice(out_kind_t k, logic [31:0] g, logic [7:0] mr);
        notice_t n;
        n.kind = k;
        n.group = g;
        n.max_resp = mr;
        n.last = 1'b0;
        pending_notices.push_back(n);
    endfunction

    function automatic void predict_membership(kind_t k, logic [31:0] g, logic [31:0] s);
        int          idx;
        int          start;
        int          n;
        int unsigned lmi;
        logic [7:0]  grp_mr;
        bit          mexp;
        bit          rexp;
        start = pending_notices.size();
        lmi = at_least_one_tick(r_lmi);
        grp_mr = (lmi > 255) ? 8'd255 : lmi[7:0];
        idx = -1;
        for (int i = 0; i < GROUP_ENTRIES; i++)
            if (idx < 0 && m_valid[i] && m_group[i] == g)
                idx = i;
        case (k)
            KIND_REPORT:
            begin
                if (idx < 0)
                begin
                    for (int i = 0; i < GROUP_ENTRIES; i++)
                        if (idx < 0 && !m_valid[i])
                            idx = i;
                    if (idx < 0)
                        push_notice(OUT_FULL, g, 8'd0);
                    else
                    begin
                        m_valid[idx] = 1'b1;
                        m_group[idx] = g;
                        push_notice(OUT_REG, g, 8'd0);
                    end
                end
                if (idx >= 0)
                begin
                    m_member[idx] = at_least_one_tick(r_gmi);
                    m_checking[idx] = 1'b0;
                    m_rexmt[idx] = 0;
                end
            end
            KIND_LEAVE:
            begin
                if (idx >= 0 && !m_checking[idx])
                begin
                    m_rexmt[idx] = lmi;
                    if (m_querier)
                        m_member[idx] = at_least_one_tick(r_lmi * r_lmc);
                    m_checking[idx] = 1'b1;
                end
            end
            KIND_QUERY:
            begin
                if (s < r_own)
                begin
                    m_qtimer = at_least_one_tick(r_oqi);
                    m_querier = 1'b0;
                end
            end
            default:
            begin
                n = 0;
                if (m_qtimer <= 1)
                begin
                    m_querier = 1'b1;
                    push_notice(OUT_GENQ, 32'd0, r_qri[7:0]);
                    n++;
                    m_qtimer = at_least_one_tick(r_qi);
                end
                else
                    m_qtimer--;
                for (int i = 0; i < GROUP_ENTRIES; i++)
                begin
                    if (m_valid[i])
                    begin
                        mexp = m_member[i] <= 1;
                        rexp = !mexp && m_rexmt[i] == 1;
                        if (!((mexp || (rexp && m_querier)) && n >= RESULT_LIMIT))
                        begin
                            if (mexp)
                            begin
                                push_notice(OUT_UNREG, m_group[i], 8'd0);
                                n++;
                                m_valid[i] = 1'b0;
                                m_checking[i] = 1'b0;
                                m_member[i] = 0;
                                m_rexmt[i] = 0;
                            end
                            else
                            begin
                                m_member[i]--;
                                if (rexp)
                                begin
                                    if (m_querier)
                                    begin
                                        push_notice(OUT_GRPQ, m_group[i], grp_mr);
                                        n++;
                                    end
                                    m_rexmt[i] = lmi;
                                    m_checking[i] = 1'b1;
                                end
                                else if (m_rexmt[i] != 0)
                                    m_rexmt[i]--;
                            end
                        end
                    end
                end
            end
        endcase
        if (pending_notices.size() > start)
            pending_notices[pending_notices.size() - 1].last = 1'b1;
    endfunction

    task automatic send_item(kind_t k, logic [31:0] g, logic [31:0] s);
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.kind = k;
        in_ch.group_addr = g;
        in_ch.sender_addr = s;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_membership(k, g, s);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic wait_drain();
        while (pending_notices.size() != 0)
            @(posedge clk);
        repeat (WALK_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            CFG_QUERY_INTERVAL:         r_qi = value[15:0];
            CFG_QUERY_RESP_INTERVAL:    r_qri = value[7:0];
            CFG_GROUP_MEMB_INTERVAL:    r_gmi = value[15:0];
            CFG_OTHER_QUERIER_INTERVAL: r_oqi = value[15:0];
            CFG_LAST_MEMBER_INTERVAL:   r_lmi = value[11:0];
            CFG_LAST_MEMBER_COUNT:      r_lmc = value[3:0];
            CFG_OWN_ADDRESS:            r_own = value;
            default: ;
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic load_config(int unsigned qi, int unsigned qri, int unsigned gmi,
                               int unsigned oqi, int unsigned lmi, int unsigned lmc,
                               logic [31:0] own);
        drop_valid();
        wait_drain();
        write_reg(CFG_QUERY_INTERVAL, qi);
        write_reg(CFG_QUERY_RESP_INTERVAL, qri);
        write_reg(CFG_GROUP_MEMB_INTERVAL, gmi);
        write_reg(CFG_OTHER_QUERIER_INTERVAL, oqi);
        write_reg(CFG_LAST_MEMBER_INTERVAL, lmi);
        write_reg(CFG_LAST_MEMBER_COUNT, lmc);
        write_reg(CFG_OWN_ADDRESS, own);
    endtask

    task automatic test_directed();
        load_config(2, 8'h5a, 4, 3, 1, 2, 32'h8000_0000);
        send_item(KIND_TICK, $urandom, $urandom);
        send_item(KIND_REPORT, 32'h0000_0000, $urandom);
        send_item(KIND_REPORT, 32'hffff_ffff, $urandom);
        send_item(KIND_REPORT, 32'h0000_0000, $urandom);
        send_item(KIND_LEAVE, 32'h0000_0000, $urandom);
        send_item(KIND_LEAVE, 32'h0000_0000, $urandom);
        send_item(KIND_LEAVE, 32'h1234_5678, $urandom);
        send_item(KIND_TICK, 32'h0, 32'h0);
        send_item(KIND_TICK, 32'hffff_ffff, 32'hffff_ffff);
        send_item(KIND_QUERY, 32'h0, 32'h8000_0001);
        send_item(KIND_QUERY, 32'h0, 32'h8000_0000);
        send_item(KIND_QUERY, 32'hffff_ffff, 32'h0000_0001);
        send_item(KIND_REPORT, 32'hffff_ffff, 32'h0);
        send_item(KIND_LEAVE, 32'hffff_ffff, 32'h0);
        repeat (6) send_item(KIND_TICK, $urandom, $urandom);
    endtask

    task automatic test_table_full();
        load_config(1000, 8'hff, 900, 5, 4, 1, 32'h0000_0000);
        for (int i = 0; i < GROUP_ENTRIES + 2; i++)
            send_item(KIND_REPORT, {8'($urandom_range(0, 255)), 24'(i)}, 32'h0);
    endtask

    task automatic test_backpressure();
        load_config(1, 8'h01, 1, 1, 1, 1, 32'h0000_0000);
        drop_valid();
        hold_cycles = 400;
        for (int i = 0; i < 14; i++)
            send_item(KIND_REPORT, group_pool[i], 32'h0);
        send_item(KIND_TICK, 32'h0, 32'h0);
        send_item(KIND_TICK, 32'h0, 32'h0);
        drop_valid();
        wait_drain();
    endtask

    task automatic test_leave_timeout();
        load_config(5000, 8'h10, 2000, 5, 3, 2, 32'h0000_0000);
        send_item(KIND_REPORT, 32'he000_0101, $urandom);
        send_item(KIND_LEAVE, 32'he000_0101, $urandom);
        repeat (8) send_item(KIND_TICK, $urandom, $urandom);
    endtask

    task automatic test_random(int count, logic [31:0] own);
        int unsigned sel;
        logic [31:0] g;
        logic [31:0] s;
        for (int i = 0; i < 16; i++)
            group_pool[i] = $urandom;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            g = ($urandom_range(0, 9) == 0) ? $urandom : group_pool[$urandom_range(0, 15)];
            s = ($urandom_range(0, 1) == 0) ? $urandom : own + $urandom_range(0, 4) - 2;
            if (sel < 35)
                send_item(KIND_REPORT, g, s);
            else if (sel < 58)
                send_item(KIND_LEAVE, g, s);
            else if (sel < 66)
                send_item(KIND_QUERY, g, s);
            else
                send_item(KIND_TICK, g, s);
        end
    endtask

    initial
    begin
        logic [31:0] own;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_TICK;
        in_ch.group_addr = '0;
        in_ch.sender_addr = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_QUERY_INTERVAL;
        cfg.data = '0;
        r_qi = 1250; r_qri = 100; r_gmi = 2600; r_oqi = 2550;
        r_lmi = 10; r_lmc = 2; r_own = 0;
        m_querier = 1'b1;
        m_qtimer = 1;
        for (int i = 0; i < GROUP_ENTRIES; i++)
        begin
            m_valid[i] = 1'b0; m_group[i] = '0; m_checking[i] = 1'b0;
            m_member[i] = 0; m_rexmt[i] = 0;
        end
        for (int i = 0; i < 16; i++)
            group_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_item(KIND_TICK, 32'h0, 32'h0);
        test_directed();
        test_table_full();
        test_backpressure();
        test_leave_timeout();
        own = $urandom;
        load_config(4, $urandom_range(1, 255), 20, 6, 2, 3, own);
        test_random(50, own);
        own = $urandom;
        load_config(0, 0, 8, 0, 0, 0, own);
        test_random(30, own);
        load_config(65535, 255, 65535, 65535, 4095, 15, 32'hffff_ffff);
        test_random(20, 32'hffff_ffff);
        own = $urandom;
        load_config(3, $urandom_range(1, 255), 12, 4, 1, 2, own);
        idle_en = 1'b0;
        test_random(45, own);
        drop_valid();
        wait_drain();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ch.ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        notice_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_notices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d group %h max_resp %0d last %0b",
                             out_ch.out_kind, out_ch.out_group, out_ch.max_resp, out_ch.last);
            end
            else
            begin
                want = pending_notices.pop_front();
                if (out_ch.out_kind !== want.kind || out_ch.out_group !== want.group ||
                    out_ch.max_resp !== want.max_resp || out_ch.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
                                 want.kind, want.group, want.max_resp, want.last,
                                 out_ch.out_kind, out_ch.out_group, out_ch.max_resp,
                                 out_ch.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
